[src/ssm_pkg.sv]
// Shared constants, types and helpers for the shear sort matrix block.
package ssm_pkg;

    localparam int MAX_SIDE  = 8;
    localparam int KEY_WIDTH = 32;
    localparam int CELLS     = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int RND_W     = $clog2(SIDE_W + 2);
    localparam int ADDR_W    = 3;

    // register map
    localparam logic [ADDR_W-1:0] REG_MATRIX_SIDE = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_RESET      = SIDE_W'(MAX_SIDE);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROW,
        ST_COL,
        ST_EMIT
    } t_state;

    // per-cell exchange control
    typedef struct packed {
        logic xchg;
        logic take_max;
    } t_xchg;

    // number of row phases: ceil(log2(side)) + 1
    function automatic logic [RND_W-1:0] f_rounds(input logic [SIDE_W-1:0] side);
        logic [SIDE_W:0]  pw;
        logic [RND_W-1:0] r;
        pw = (SIDE_W+1)'(1);
        r  = RND_W'(1);
        for (int i = 0; i < SIDE_W; i++) begin
            if (pw < {1'b0, side}) begin
                pw = pw << 1;
                r  = r + RND_W'(1);
            end
        end
        return r;
    endfunction

endpackage

[src/shear_sort_matrix.sv]
// Top level of the shear sort matrix: loader, phase sequencer, 8x8 cell grid.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  key in   | i_key_valid/o_key_ready, i_key_value      | in
//  sorted   | o_sorted_valid/i_sorted_ready, key, last  | out
//  config   | APB: psel penable pwrite paddr pwdata     | in
//
// Flow: side*side keys are loaded, then each round runs side odd-even
// transposition steps on the rows and, except in the last round, side
// steps on the columns; then side*side sorted keys are emitted. The
// transposition step count of the cell grid sets the sort time.
// Reset clears the sequencer and load counters and sets the side to 8.
// A stalled output holds the current key; nothing else moves meanwhile but a side write, which resets the position.
// No new key is taken while sorting or emitting.
module shear_sort_matrix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_key_valid,
    output logic                                 o_key_ready,
    input  logic signed [ssm_pkg::KEY_WIDTH-1:0] i_key_value,
    output logic                                 o_sorted_valid,
    input  logic                                 i_sorted_ready,
    output logic signed [ssm_pkg::KEY_WIDTH-1:0] o_sorted_key,
    output logic                                 o_last_key,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ssm_pkg::ADDR_W-1:0]           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import ssm_pkg::*;

    t_state r_state, n_state;

    logic [SIDE_W-1:0] r_side_raw;
    logic [SIDE_W-1:0] w_side;
    logic [IDX_W-1:0]  w_side_m1;
    logic [RND_W-1:0]  w_rounds;

    logic [IDX_W-1:0] r_row, n_row;   // load / emit row
    logic [IDX_W-1:0] r_col, n_col;   // load / emit column
    logic [IDX_W-1:0] r_step, n_step; // transposition step
    logic [RND_W-1:0] r_rnd, n_rnd;

    logic w_cfg_wr;
    logic w_in_acc;
    logic w_at_end;

    logic signed [KEY_WIDTH-1:0] w_key [CELLS];

    // effective side: 0 acts as 1, above MAX_SIDE acts as MAX_SIDE
    always_comb begin
        if (r_side_raw == '0) begin
            w_side = SIDE_W'(1);
        end else if (r_side_raw > SIDE_W'(MAX_SIDE)) begin
            w_side = SIDE_W'(MAX_SIDE);
        end else begin
            w_side = r_side_raw;
        end
    end
    assign w_side_m1 = IDX_W'(w_side - SIDE_W'(1));
    assign w_rounds  = f_rounds(w_side);

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == REG_MATRIX_SIDE);
    assign prdata   = (paddr == REG_MATRIX_SIDE) ? {{(32-SIDE_W){1'b0}}, r_side_raw} : '0;

    assign o_key_ready    = (r_state == ST_LOAD);
    assign w_in_acc       = i_key_valid && o_key_ready;
    assign o_sorted_valid = (r_state == ST_EMIT);
    assign w_at_end       = (r_row == w_side_m1) && (r_col == w_side_m1);
    assign o_last_key     = w_at_end;
    assign o_sorted_key   = w_key[{r_row, r_col}];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_step  = r_step;
        n_rnd   = r_rnd;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (r_col == w_side_m1) begin
                        n_col = '0;
                        n_row = r_row + IDX_W'(1);
                    end else begin
                        n_col = r_col + IDX_W'(1);
                    end
                    if (w_at_end) begin
                        n_row   = '0;
                        n_step  = '0;
                        n_rnd   = RND_W'(1);
                        n_state = ST_ROW;
                    end
                end
            end
            ST_ROW: begin
                n_step = r_step + IDX_W'(1);
                if (r_step == w_side_m1) begin
                    n_step  = '0;
                    n_state = (r_rnd == w_rounds) ? ST_EMIT : ST_COL;
                end
            end
            ST_COL: begin
                n_step = r_step + IDX_W'(1);
                if (r_step == w_side_m1) begin
                    n_step  = '0;
                    n_rnd   = r_rnd + RND_W'(1);
                    n_state = ST_ROW;
                end
            end
            ST_EMIT: begin
                if (i_sorted_ready) begin
                    if (r_col == w_side_m1) begin
                        n_col = '0;
                        n_row = r_row + IDX_W'(1);
                    end else begin
                        n_col = r_col + IDX_W'(1);
                    end
                    if (w_at_end) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
        if (w_cfg_wr) begin
            n_row = '0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_side_raw <= SIDE_RESET;
            r_row      <= '0;
            r_col      <= '0;
            r_step     <= '0;
            r_rnd      <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_step  <= n_step;
            r_rnd   <= n_rnd;
            if (w_cfg_wr) begin
                r_side_raw <= pwdata[SIDE_W-1:0];
            end
        end
    end

    // cell grid: rows sort in snake order, columns ascending, by odd-even
    // transposition; a cell pairs with its right/left or lower/upper neighbor
    for (genvar gr = 0; gr < MAX_SIDE; gr++) begin : g_row
        for (genvar gc = 0; gc < MAX_SIDE; gc++) begin : g_col
            localparam int ME = gr * MAX_SIDE + gc;
            localparam int RT = (gc < MAX_SIDE - 1) ? ME + 1 : ME;
            localparam int LT = (gc > 0) ? ME - 1 : ME;
            localparam int DN = (gr < MAX_SIDE - 1) ? ME + MAX_SIDE : ME;
            localparam int UP = (gr > 0) ? ME - MAX_SIDE : ME;

            t_xchg                       w_ctl;
            logic signed [KEY_WIDTH-1:0] w_partner;
            logic                        w_load;
            logic                        w_in;
            logic                        w_first;
            logic                        w_second;

            assign w_load = w_in_acc && (r_row == IDX_W'(gr)) && (r_col == IDX_W'(gc));
            assign w_in   = (SIDE_W'(gr) < w_side) && (SIDE_W'(gc) < w_side);

            always_comb begin
                w_ctl     = '0;
                w_partner = w_key[ME];
                w_first   = 1'b0;
                w_second  = 1'b0;
                if (r_state == ST_ROW) begin
                    w_first  = ((gc % 2) == int'(r_step[0])) && (SIDE_W'(gc + 1) < w_side);
                    w_second = ((gc % 2) != int'(r_step[0])) && (gc > 0);
                    if (w_first) begin
                        w_partner     = w_key[RT];
                        w_ctl.take_max = ((gr % 2) == 1);
                    end else begin
                        w_partner     = w_key[LT];
                        w_ctl.take_max = ((gr % 2) == 0);
                    end
                    w_ctl.xchg = w_in && (w_first || w_second);
                end else if (r_state == ST_COL) begin
                    w_first  = ((gr % 2) == int'(r_step[0])) && (SIDE_W'(gr + 1) < w_side);
                    w_second = ((gr % 2) != int'(r_step[0])) && (gr > 0);
                    if (w_first) begin
                        w_partner     = w_key[DN];
                        w_ctl.take_max = 1'b0;
                    end else begin
                        w_partner     = w_key[UP];
                        w_ctl.take_max = 1'b1;
                    end
                    w_ctl.xchg = w_in && (w_first || w_second);
                end
            end

            ssm_cell u_cell (
                .i_clk      (i_clk),
                .i_load     (w_load),
                .i_load_key (i_key_value),
                .i_ctl      (w_ctl),
                .i_partner  (w_partner),
                .o_key      (w_key[ME])
            );
        end
    end
endmodule

[src/ssm_cell.sv]
// One matrix cell: holds a key, loads it, or keeps min/max against a neighbor.
module ssm_cell (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic signed [ssm_pkg::KEY_WIDTH-1:0] i_load_key,
    input  ssm_pkg::t_xchg                    i_ctl,
    input  logic signed [ssm_pkg::KEY_WIDTH-1:0] i_partner,
    output logic signed [ssm_pkg::KEY_WIDTH-1:0] o_key
);
    import ssm_pkg::*;

    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] n_key;
    logic                        w_less;

    assign w_less = i_partner < r_key;

    always_comb begin
        n_key = r_key;
        if (i_load) begin
            n_key = i_load_key;
        end else if (i_ctl.xchg) begin
            if (i_ctl.take_max) begin
                n_key = w_less ? r_key : i_partner;
            end else begin
                n_key = w_less ? i_partner : r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
endmodule

[src/ssm_checker.sv]
// Port-level checks for the shear sort matrix, bound to the top level.
module ssm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_key_valid,
    input logic                                 o_key_ready,
    input logic                                 o_sorted_valid,
    input logic                                 i_sorted_ready,
    input logic signed [ssm_pkg::KEY_WIDTH-1:0] o_sorted_key,
    input logic                                 o_last_key
);
    import ssm_pkg::*;

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sorted_valid |-> !o_key_ready)
        else $error("key taken while emitting");

    // a key taken is never followed at once by output
    a_sort_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_key_valid && o_key_ready) |=> !o_sorted_valid)
        else $error("output right after load");

    // after the last key, the block returns to loading
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sorted_valid && i_sorted_ready && o_last_key) |=> (!o_sorted_valid && o_key_ready))
        else $error("emit did not end on last key");

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sorted_valid && !i_sorted_ready) |=>
            (o_sorted_valid && $stable(o_sorted_key) && $stable(o_last_key)))
        else $error("stalled output changed");
endmodule

bind shear_sort_matrix ssm_checker u_ssm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_key_valid    (i_key_valid),
    .o_key_ready    (o_key_ready),
    .o_sorted_valid (o_sorted_valid),
    .i_sorted_ready (i_sorted_ready),
    .o_sorted_key   (o_sorted_key),
    .o_last_key     (o_last_key)
);

[tb/tb.sv]
// Testbench for shear_sort_matrix: matrix loads, shear sort prediction, result checks.
`timescale 1ns / 1ps

// Holds the predicted matrix state and the queue of sorted keys still owed.
class sort_board;
    logic signed [ssm_pkg::KEY_WIDTH-1:0] grid [ssm_pkg::CELLS];
    logic signed [ssm_pkg::KEY_WIDTH-1:0] owed_key [$];
    bit                                   owed_last [$];
    int unsigned                          loaded;
    logic [3:0]                           side_reg;
    int                                   errors;

    function new();
        loaded   = 0;
        side_reg = 4'd8;
        errors   = 0;
    endfunction

    function void report(string what);
        errors++;
        $display("mismatch: %s", what);
    endfunction

    function int side_in_use();
        if (side_reg == 0) return 1;
        if (side_reg > ssm_pkg::MAX_SIDE) return ssm_pkg::MAX_SIDE;
        return side_reg;
    endfunction

    // any write to the side register drops a partial load
    function void write_reg(logic [ssm_pkg::ADDR_W-1:0] addr, logic [31:0] data);
        if (addr == ssm_pkg::REG_MATRIX_SIDE) begin
            side_reg = data[3:0];
            loaded   = 0;
        end
    endfunction

    function void sort_line(int base, int stride, int n, bit desc);
        logic signed [ssm_pkg::KEY_WIDTH-1:0] v, p;
        int j;
        for (int i = 1; i < n; i++) begin
            v = grid[base + i*stride];
            j = i;
            while (j > 0) begin
                p = grid[base + (j-1)*stride];
                if (desc ? !(p < v) : !(v < p)) break;
                grid[base + j*stride] = p;
                j--;
            end
            grid[base + j*stride] = v;
        end
    endfunction

    function void note_key(logic signed [ssm_pkg::KEY_WIDTH-1:0] k);
        int s, total, rounds, pw;
        s     = side_in_use();
        total = s * s;
        grid[loaded] = k;
        loaded++;
        if (loaded < total) return;
        rounds = 1;
        pw     = 1;
        while (pw < s) begin
            pw = pw << 1;
            rounds++;
        end
        for (int r = 0; r < rounds; r++) begin
            for (int row = 0; row < s; row++) sort_line(row*s, 1, s, row[0]);
            if (r + 1 < rounds)
                for (int c = 0; c < s; c++) sort_line(c, s, s, 1'b0);
        end
        for (int i = 0; i < total; i++) begin
            owed_key.push_back(grid[i]);
            owed_last.push_back(i + 1 == total);
        end
        loaded = 0;
    endfunction

    function void check(logic signed [ssm_pkg::KEY_WIDTH-1:0] k, logic last);
        logic signed [ssm_pkg::KEY_WIDTH-1:0] ek;
        bit el;
        if (owed_key.size() == 0) begin
            report($sformatf("unexpected key %0d", k));
            return;
        end
        ek = owed_key.pop_front();
        el = owed_last.pop_front();
        if (k !== ek) report($sformatf("sorted_key %0d, want %0d", k, ek));
        if (last !== el) report($sformatf("last_key %0b, want %0b", last, el));
    endfunction
endclass

[tb/tb_top.sv]
// Top of the shear sort testbench: clock, reset, drivers, monitor and run sequence.
`timescale 1ns / 1ps

module tb;
    import ssm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;   // block returns to load right after the last key

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_key_valid = 1'b0;
    logic                        o_key_ready;
    logic signed [KEY_WIDTH-1:0] i_key_value = '0;
    logic                        o_sorted_valid;
    logic                        i_sorted_ready = 1'b0;
    logic signed [KEY_WIDTH-1:0] o_sorted_key;
    logic                        o_last_key;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ADDR_W-1:0]           paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    sort_board board = new();
    int unsigned cycles = 0;
    int          burst_left = 0;
    int          ready_mode = 0;

    shear_sort_matrix dut (.*);

    always #1 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: stall pattern switches among always-ready, coin flip and sparse
    always @(posedge i_clk) begin
        if (cycles % 97 == 0) ready_mode <= $urandom_range(0, 2);
        case (ready_mode)
            0: begin
                i_sorted_ready <= 1'b1;
            end
            1: begin
                i_sorted_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_sorted_ready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // result monitor: sampled at the edge, before outputs update
    always @(posedge i_clk) begin
        if (i_rst_n && o_sorted_valid && i_sorted_ready)
            board.check(o_sorted_key, o_last_key);
    end

    // one key: raise valid, hold until taken; bursts with random gaps between
    task automatic send_key(logic signed [KEY_WIDTH-1:0] k);
        if (burst_left == 0) begin
            i_key_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        i_key_valid <= 1'b1;
        i_key_value <= k;
        @(posedge i_clk);
        while (!o_key_ready) @(posedge i_clk);
        board.note_key(k);
        burst_left--;
    endtask

    task automatic wait_drained();
        i_key_valid <= 1'b0;
        while (board.owed_key.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // setup then access; pready is tied high so the access phase has no wait states
    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        i_key_valid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.write_reg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [KEY_WIDTH-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 6))) - 3;   // many duplicates
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_matrix(int count);
        for (int i = 0; i < count; i++) send_key(pick_key());
    endtask

    initial begin
        int sides [9] = '{15, 4, 7, 5, 6, 2, 3, 1, 0};
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: side one passes keys straight through, extremes included
        apb_write(REG_MATRIX_SIDE, 32'd1);
        send_key(32'sh8000_0000);
        send_key(32'sh7fff_ffff);
        send_key(32'sh0000_0000);
        send_key(-32'sd1);
        wait_drained();
        // side zero behaves as side one
        apb_write(REG_MATRIX_SIDE, 32'd0);
        send_key(32'sh5555_aaaa);
        wait_drained();
        // smallest real sort
        apb_write(REG_MATRIX_SIDE, 32'd2);
        send_key(32'sh7fff_ffff);
        send_key(32'sh8000_0000);
        send_key(-32'sd1);
        send_key(32'sd1);
        wait_drained();
        // partial load dropped by a side rewrite; stray address ignored
        apb_write(REG_MATRIX_SIDE, 32'd3);
        send_key(32'sd100);
        send_key(-32'sd100);
        send_key(32'sd7);
        wait_drained();
        apb_write(REG_MATRIX_SIDE, 32'd3);
        apb_write(3'd4, 32'd5);
        for (int i = 0; i < 9; i++) send_key(32'sd4 - i);
        wait_drained();

        // random: a sweep of side settings, the oversized one (full 8x8) first
        foreach (sides[s]) begin
            apb_write(REG_MATRIX_SIDE, sides[s]);
            n = board.side_in_use() * board.side_in_use();
            if ($urandom_range(0, 2) == 0 && n > 1) begin
                send_matrix($urandom_range(1, n - 1));
                wait_drained();
                apb_write(REG_MATRIX_SIDE, sides[s]);
            end
            for (int sent = 0; sent < 12; sent += n) send_matrix(n);
            wait_drained();
        end

        wait_drained();
        if (board.owed_key.size() != 0)
            board.report($sformatf("%0d keys never emitted", board.owed_key.size()));
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
